[hdl/lbsm_pkg.sv]
// Shared types, codes and sizes for the LRU buffer slot manager.
// No dependencies; every other file in hdl/ imports this package.
`default_nettype none

package lbsm_pkg;

  // Default parameter values
  localparam int SLOT_COUNT_DEF       = 32;
  localparam int DISK_BLOCK_COUNT_DEF = 8192;

  // Field widths fixed by the interface
  localparam int OP_W        = 2;
  localparam int BLK_W       = 14;
  localparam int WB_BLK_W    = 13;
  localparam int SLOT_OUT_W  = 5;
  localparam int STAT_W      = 2;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;

  // Age counters
  localparam int AGE_W     = 16;
  localparam int AGE_BIT_W = $clog2(AGE_W);

  // Request queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Opcodes
  localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
  localparam logic [OP_W-1:0] OP_DIRTY  = 2'd2;
  localparam logic [OP_W-1:0] OP_NOP    = 2'd3;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BOUND = 2'd1;
  localparam logic [STAT_W-1:0] STAT_MISS  = 2'd2;

  // Classified request kinds
  localparam int KIND_W = 3;
  localparam logic [KIND_W-1:0] KIND_NOP    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_BOUND  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ALLOC  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_LOOKUP = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DIRTY  = 3'd4;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BLK_W-1:0]  blk;
  } lbsm_req_t;

endpackage

`default_nettype wire

[hdl/lbsm_front.sv]
// Front end: accepts requests from the input stream and classifies them.
// Depends on lbsm_pkg; feeds lbsm_queue.
`default_nettype none

module lbsm_front
  import lbsm_pkg::*;
#(
  parameter int DISK_BLOCK_COUNT = DISK_BLOCK_COUNT_DEF
) (
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_TDATA_W-1:0] in_tdata,
  input  wire logic [OP_W-1:0]       in_tuser,
  output logic                       push_valid,
  input  wire logic                  push_ready,
  output lbsm_req_t                  push_req
);

  logic [BLK_W-1:0] blk;
  logic             out_of_bound;

  assign blk          = in_tdata[BLK_W-1:0];
  assign out_of_bound = {1'b0, blk} >= (BLK_W+1)'(DISK_BLOCK_COUNT);

  assign in_tready  = push_ready;
  assign push_valid = in_tvalid;

  // unused opcode wins over the bound check
  always_comb begin
    push_req.blk = blk;
    case (in_tuser)
      OP_NOP:    push_req.kind = KIND_NOP;
      OP_ALLOC:  push_req.kind = out_of_bound ? KIND_BOUND : KIND_ALLOC;
      OP_LOOKUP: push_req.kind = out_of_bound ? KIND_BOUND : KIND_LOOKUP;
      OP_DIRTY:  push_req.kind = out_of_bound ? KIND_BOUND : KIND_DIRTY;
      default:   push_req.kind = KIND_NOP;
    endcase
  end

endmodule

`default_nettype wire

[hdl/lbsm_queue.sv]
// Short request queue between the classifying front and the executing back.
// Depends on lbsm_pkg.
`default_nettype none

module lbsm_queue
  import lbsm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push_valid,
  output logic           push_ready,
  input  wire lbsm_req_t push_req,
  output logic           pop_valid,
  input  wire logic      pop_ready,
  output lbsm_req_t      pop_req
);

  lbsm_req_t         entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign push_ready = count_r != QCNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_req    = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_req;
    end
  end

endmodule

`default_nettype wire

[hdl/lbsm_back.sv]
// Back end: slot store (valid, dirty, age, tag), request execution and the
// result register. Depends on lbsm_pkg; takes requests from lbsm_queue.
`default_nettype none

module lbsm_back
  import lbsm_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   pop_valid,
  output logic                        pop_ready,
  input  wire lbsm_req_t              pop_req,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  output logic [STAT_W-1:0]           out_tuser
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [SLOT_COUNT-1:0] slot_valid_r, slot_valid_nxt;
  logic [SLOT_COUNT-1:0] slot_dirty_r, slot_dirty_nxt;
  logic [AGE_W-1:0]      slot_age_r [SLOT_COUNT];
  logic [AGE_W-1:0]      slot_age_nxt [SLOT_COUNT];
  logic [BLK_W-1:0]      slot_tag_r [SLOT_COUNT];
  logic [BLK_W-1:0]      slot_tag_nxt [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] cand_r, cand_nxt;
  logic [AGE_BIT_W-1:0]  bit_r, bit_nxt;
  logic [BLK_W-1:0]      blk_r, blk_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]     out_status_r, out_status_nxt;
  logic [SLOT_OUT_W-1:0] out_slot_r, out_slot_nxt;
  logic                  out_wb_valid_r, out_wb_valid_nxt;
  logic [WB_BLK_W-1:0]   out_wb_block_r, out_wb_block_nxt;
  logic                  out_load;

  logic                  out_free;
  logic [SLOT_COUNT-1:0] match;
  logic [SLOT_COUNT-1:0] age_bit;
  logic [SLOT_COUNT-1:0] hit;
  logic [IDX_W-1:0]      match_idx, free_idx, victim_idx;

  function automatic logic [IDX_W-1:0] first_set(input logic [SLOT_COUNT-1:0] v);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (v[i]) r = IDX_W'(i);
    end
    return r;
  endfunction

  assign out_free  = !out_valid_r || out_tready;
  assign pop_ready = (state_r == S_IDLE) && out_free;

  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      match[i]   = slot_valid_r[i] && (slot_tag_r[i] == pop_req.blk);
      age_bit[i] = slot_age_r[i][bit_r];
    end
  end

  assign hit        = cand_r & age_bit;
  assign match_idx  = first_set(match);
  assign free_idx   = first_set(~slot_valid_r);
  assign victim_idx = first_set(cand_r);

  always_comb begin
    state_nxt        = state_r;
    slot_valid_nxt   = slot_valid_r;
    slot_dirty_nxt   = slot_dirty_r;
    slot_age_nxt     = slot_age_r;
    slot_tag_nxt     = slot_tag_r;
    cand_nxt         = cand_r;
    bit_nxt          = bit_r;
    blk_nxt          = blk_r;
    out_load         = 1'b0;
    out_status_nxt   = STAT_OK;
    out_slot_nxt     = '0;
    out_wb_valid_nxt = 1'b0;
    out_wb_block_nxt = '0;

    case (state_r)
      S_IDLE: begin
        if (pop_valid && out_free) begin
          case (pop_req.kind)
            KIND_NOP: begin
              out_load = 1'b1;
            end
            KIND_BOUND: begin
              out_load       = 1'b1;
              out_status_nxt = STAT_BOUND;
            end
            KIND_LOOKUP, KIND_DIRTY: begin
              out_load = 1'b1;
              if (|match) begin
                out_slot_nxt = SLOT_OUT_W'(match_idx);
                if (pop_req.kind == KIND_DIRTY) begin
                  slot_dirty_nxt[match_idx] = 1'b1;
                end
              end else begin
                out_status_nxt = STAT_MISS;
              end
            end
            KIND_ALLOC: begin
              // age every valid slot, saturating
              for (int i = 0; i < SLOT_COUNT; i++) begin
                if (slot_valid_r[i] && (slot_age_r[i] != '1)) begin
                  slot_age_nxt[i] = slot_age_r[i] + 1'b1;
                end
              end
              if (!(&slot_valid_r)) begin
                out_load                 = 1'b1;
                out_slot_nxt             = SLOT_OUT_W'(free_idx);
                slot_valid_nxt[free_idx] = 1'b1;
                slot_dirty_nxt[free_idx] = 1'b0;
                slot_age_nxt[free_idx]   = '0;
                slot_tag_nxt[free_idx]   = pop_req.blk;
              end else begin
                // full: hunt the oldest slot one age bit per cycle
                state_nxt = S_SEARCH;
                cand_nxt  = '1;
                bit_nxt   = AGE_BIT_W'(AGE_W - 1);
                blk_nxt   = pop_req.blk;
              end
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      S_SEARCH: begin
        if (|hit) begin
          cand_nxt = hit;
        end
        if (bit_r == '0) begin
          state_nxt = S_COMMIT;
        end else begin
          bit_nxt = bit_r - 1'b1;
        end
      end
      S_COMMIT: begin
        if (out_free) begin
          out_load                   = 1'b1;
          out_slot_nxt               = SLOT_OUT_W'(victim_idx);
          out_wb_valid_nxt           = slot_dirty_r[victim_idx];
          out_wb_block_nxt           = slot_dirty_r[victim_idx] ?
                                       WB_BLK_W'(slot_tag_r[victim_idx]) : '0;
          slot_valid_nxt[victim_idx] = 1'b1;
          slot_dirty_nxt[victim_idx] = 1'b0;
          slot_age_nxt[victim_idx]   = '0;
          slot_tag_nxt[victim_idx]   = blk_r;
          state_nxt                  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = out_load || (out_valid_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      slot_valid_r <= '0;
      slot_dirty_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      slot_valid_r <= slot_valid_nxt;
      slot_dirty_r <= slot_dirty_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // ages and tags of free slots are never read, so they need no reset
  always_ff @(posedge clk) begin
    slot_age_r <= slot_age_nxt;
    slot_tag_r <= slot_tag_nxt;
    cand_r     <= cand_nxt;
    bit_r      <= bit_nxt;
    blk_r      <= blk_nxt;
    if (out_load) begin
      out_status_r   <= out_status_nxt;
      out_slot_r     <= out_slot_nxt;
      out_wb_valid_r <= out_wb_valid_nxt;
      out_wb_block_r <= out_wb_block_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {(OUT_TDATA_W - SLOT_OUT_W - 1 - WB_BLK_W)'(0),
                       out_wb_block_r, out_wb_valid_r, out_slot_r};

  a_cand_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEARCH || state_r == S_COMMIT) |-> (cand_r != '0))
    else $error("victim search lost every candidate");

  a_search_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEARCH) |-> (&slot_valid_r))
    else $error("victim search started with a free slot");

  a_quiet_fail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != STAT_OK) |->
      (out_slot_r == '0 && !out_wb_valid_r && out_wb_block_r == '0))
    else $error("failed request carries a slot or writeback");

  a_dirty_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (slot_dirty_r & ~slot_valid_r) == '0)
    else $error("free slot marked dirty");

endmodule

`default_nettype wire

[hdl/lru_buffer_slot_manager.sv]
// Top level of the LRU buffer slot manager: front, request queue and back.
// Depends on lbsm_pkg, lbsm_front, lbsm_queue and lbsm_back.
`default_nettype none

// Tag and replacement store for a fully associative pool of SLOT_COUNT
// buffer slots. Each request on the input stream carries an opcode in
// in_tuser (allocate, look up, mark dirty) and a disk block number in
// in_tdata; each request yields exactly one result on the output stream,
// in request order. Block numbers at or above DISK_BLOCK_COUNT are answered
// with the bound status and change nothing. Allocate ages every held slot
// by one (saturating at the top of the 16-bit counter) and claims the
// lowest free slot; when the pool is full it evicts the lowest-index slot of
// greatest age and reports a writeback with the old block number if that
// slot was dirty. Requests are classified on entry and wait in a two-entry
// queue, so input is taken while a result waits on a stalled output.
// Lookup, mark dirty, a bound or unused request and an allocate that finds
// a free slot are each finished as the back end takes them, so such
// requests stream at one per cycle while the output is not stalled, and
// the result register is loaded as the request is taken. An allocate into
// a full pool first ages the held slots, then narrows the candidates one
// age bit at a time from the top, and last picks the victim and writes it.
// No clearing pass is needed after reset.
module lru_buffer_slot_manager
  import lbsm_pkg::*;
#(
  parameter int SLOT_COUNT       = SLOT_COUNT_DEF,
  parameter int DISK_BLOCK_COUNT = DISK_BLOCK_COUNT_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // [13:0] block_number, [15:14] zero
  input  wire logic [OP_W-1:0]        in_tuser,   // [1:0] opcode
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // [4:0] slot_index, [5] writeback_valid,
                                                  // [18:6] writeback_block, [23:19] zero
  output logic [STAT_W-1:0]           out_tuser   // [1:0] status
);

  // requests from the front into the queue
  logic      push_valid;
  logic      push_ready;
  lbsm_req_t push_req;

  // requests from the queue into the back
  logic      pop_valid;
  logic      pop_ready;
  lbsm_req_t pop_req;

  // classify: flag out-of-bound blocks, fold the unused opcode to a no-op
  lbsm_front #(
    .DISK_BLOCK_COUNT (DISK_BLOCK_COUNT)
  ) u_front (
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_req   (push_req)
  );

  // hold classified requests while the back is busy searching or stalled
  lbsm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_req   (push_req),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_req    (pop_req)
  );

  // execute against the slot store and register the result
  lbsm_back #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_req    (pop_req),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for lru_buffer_slot_manager: directed and random requests,
// predicted by a behavioural model of the slot store and checked result by result.
// Depends on lbsm_pkg and the RTL under hdl/.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lbsm_pkg::*;

  localparam int SLOTS           = SLOT_COUNT_DEF;
  localparam int BLOCK_LIMIT     = DISK_BLOCK_COUNT_DEF;
  localparam int BLK_TOP         = (1 << BLK_W) - 1;
  localparam int IDLE_LIMIT      = 2000;  // cycles with no handshake before giving up
  localparam int HOLD_OFF_CYCLES = 300;   // long receiver stall for the back-pressure test
  localparam int DRAIN_CYCLES    = 40;    // well beyond the eviction path

  // One result as the block reports it
  typedef struct packed {
    logic [STAT_W-1:0]     status;
    logic [SLOT_OUT_W-1:0] slot;
    logic                  wb_valid;
    logic [WB_BLK_W-1:0]   wb_block;
  } slot_result_t;

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [OP_W-1:0]        in_tuser   = OP_NOP;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STAT_W-1:0]      out_tuser;

  // Shadow copy of the slot store
  bit                 slot_held  [SLOTS];
  bit                 slot_dirty [SLOTS];
  logic [AGE_W-1:0]   slot_age   [SLOTS];
  logic [BLK_W-1:0]   slot_block [SLOTS];

  slot_result_t expected_results[$];
  int           mismatch_count  = 0;
  int           results_seen    = 0;
  int           hold_off_cycles = 0;
  bit           steady_flow     = 1'b0;

  lru_buffer_slot_manager DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Apply one request to the shadow store and return the result it must give.
  // Ages never reach saturation with this pool size: a full pool always evicts
  // the oldest slot, so the model keeps the saturating add only for form.
  function automatic slot_result_t apply_slot_request(logic [OP_W-1:0] op,
                                                      logic [BLK_W-1:0] blk);
    slot_result_t r;
    int           s;
    r = '0;
    r.status = STAT_OK;
    s = -1;
    if (op == OP_NOP) begin
      // unused opcode: answer success, touch nothing
    end else if (blk >= BLOCK_LIMIT) begin
      r.status = STAT_BOUND;
    end else if (op == OP_ALLOC) begin
      for (int i = 0; i < SLOTS; i++)
        if (slot_held[i] && slot_age[i] != '1) slot_age[i] = slot_age[i] + 1'b1;
      for (int i = 0; i < SLOTS; i++)
        if (!slot_held[i] && s < 0) s = i;
      if (s < 0) begin
        // full pool: take the lowest-index slot of greatest age
        s = 0;
        for (int i = 1; i < SLOTS; i++)
          if (slot_age[i] > slot_age[s]) s = i;
        if (slot_dirty[s]) begin
          r.wb_valid = 1'b1;
          r.wb_block = slot_block[s][WB_BLK_W-1:0];
        end
      end
      slot_held[s]  = 1'b1;
      slot_dirty[s] = 1'b0;
      slot_age[s]   = '0;
      slot_block[s] = blk;
      r.slot = s[SLOT_OUT_W-1:0];
    end else begin
      // look up and mark dirty act on the lowest matching slot
      for (int i = 0; i < SLOTS; i++)
        if (s < 0 && slot_held[i] && slot_block[i] == blk) s = i;
      if (s < 0) begin
        r.status = STAT_MISS;
      end else begin
        if (op == OP_DIRTY) slot_dirty[s] = 1'b1;
        r.slot = s[SLOT_OUT_W-1:0];
      end
    end
    return r;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Offer one request, hold it until taken, then predict its result
  task automatic issue_request(input logic [OP_W-1:0] op, input logic [BLK_W-1:0] blk);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{(IN_TDATA_W - BLK_W){1'b0}}, blk};
    do @(posedge clk); while (!in_tready);
    expected_results.push_back(apply_slot_request(op, blk));
    gap = steady_flow ? 0 : pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Prefer a block that some slot currently holds, so requests mostly hit
  function automatic logic [BLK_W-1:0] pick_known_block(int span);
    int s;
    if ($urandom_range(0, 9) < 8) begin
      s = $urandom_range(0, SLOTS - 1);
      if (slot_held[s]) return slot_block[s];
    end
    return BLK_W'($urandom_range(0, span - 1));
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("result %0d: %s got %0d, expected %0d", results_seen, field, got, want);
    mismatch_count++;
  endtask

  // Extremes of the block number, every opcode, misses, duplicates and bound cases
  task automatic test_directed_cases();
    issue_request(OP_ALLOC,  14'd0);
    issue_request(OP_ALLOC,  BLK_W'(BLOCK_LIMIT - 1));
    issue_request(OP_LOOKUP, BLK_W'(BLOCK_LIMIT - 1));
    issue_request(OP_LOOKUP, 14'd0);
    issue_request(OP_DIRTY,  BLK_W'(BLOCK_LIMIT - 1));
    issue_request(OP_LOOKUP, 14'd77);
    issue_request(OP_DIRTY,  14'd77);
    issue_request(OP_ALLOC,  14'd0);          // same block again takes a second slot
    issue_request(OP_LOOKUP, 14'd0);
    issue_request(OP_DIRTY,  14'd0);
    issue_request(OP_ALLOC,  BLK_W'(BLOCK_LIMIT));    // first out-of-bound value
    issue_request(OP_LOOKUP, BLK_W'(BLK_TOP));
    issue_request(OP_DIRTY,  14'd12000);
    issue_request(OP_NOP,    BLK_W'(BLK_TOP));
    issue_request(OP_NOP,    14'd5);
    issue_request(OP_ALLOC,  14'h0aaa);
    issue_request(OP_ALLOC,  14'h1555);
    issue_request(OP_DIRTY,  14'h1555);
    issue_request(OP_LOOKUP, 14'h0aaa);
    issue_request(OP_LOOKUP, 14'd1);
  endtask

  // Mixed traffic over a window of block numbers; small windows force evictions
  task automatic test_random_traffic(input int count, input int span, input bit no_idle);
    int r;
    steady_flow = no_idle;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 4)
        issue_request(OP_NOP, BLK_W'($urandom_range(0, BLK_TOP)));
      else if (r < 10)
        issue_request(OP_W'($urandom_range(0, 2)),
                      BLK_W'($urandom_range(BLOCK_LIMIT, BLK_TOP)));
      else if (r < 50)
        issue_request(OP_ALLOC, BLK_W'($urandom_range(0, span - 1)));
      else if (r < 75)
        issue_request(OP_LOOKUP, pick_known_block(span));
      else
        issue_request(OP_DIRTY, pick_known_block(span));
    end
    steady_flow = 1'b0;
  endtask

  // Stall the receiver for a long stretch while requests keep coming
  task automatic test_backpressure();
    hold_off_cycles = HOLD_OFF_CYCLES;
    steady_flow = 1'b1;
    for (int n = 0; n < 24; n++) begin
      if (n % 3 == 0) issue_request(OP_ALLOC, BLK_W'($urandom_range(0, 47)));
      else            issue_request(OP_DIRTY, pick_known_block(48));
    end
    steady_flow = 1'b0;
  endtask

  // Receiver: random stalls, the requested hold-off, or steady acceptance
  int rx_stall = 0;
  always @(posedge clk) begin
    if (rx_stall > 0) begin
      out_tready <= 1'b0;
      rx_stall <= rx_stall - 1;
    end else if (hold_off_cycles > 0) begin
      out_tready <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else if (!steady_flow && $urandom_range(0, 99) < 20) begin
      out_tready <= 1'b0;
      rx_stall <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(3, 39);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Compare each result taken with the oldest prediction
  always @(posedge clk) begin : check_results
    slot_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $display("result %0d: arrived with no request outstanding", results_seen);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_tuser != want.status)
          report_mismatch("status", out_tuser, want.status);
        if (out_tdata[4:0] != want.slot)
          report_mismatch("slot_index", out_tdata[4:0], want.slot);
        if (out_tdata[5] != want.wb_valid)
          report_mismatch("writeback_valid", out_tdata[5], want.wb_valid);
        if (out_tdata[18:6] != want.wb_block)
          report_mismatch("writeback_block", out_tdata[18:6], want.wb_block);
      end
    end
  end

  // Watchdog: give up after a long run of cycles without any handshake
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
      $display("testbench: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_random_traffic(600, 40, 1'b0);
    test_random_traffic(400, BLOCK_LIMIT, 1'b0);
    test_backpressure();
    test_random_traffic(300, 64, 1'b1);
    test_random_traffic(500, 36, 1'b0);
    in_tvalid <= 1'b0;
    // drain outstanding results, then watch for strays
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule

[filelist.f]
hdl/lbsm_pkg.sv
hdl/lbsm_front.sv
hdl/lbsm_queue.sv
hdl/lbsm_back.sv
hdl/lru_buffer_slot_manager.sv
tb/testbench.sv
